// File: rtl/core/bsf_pkg.sv
// ----------------------------------------------------------------------------
// bsf_pkg
// Types, widths and helpers shared by the bounding sphere fit block.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int MaxPoints = 1024;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CntW      = AddrW + 1;
  localparam int CoordW    = 16;
  localparam int FracW     = 8;
  localparam int ScW       = 28;          // scaled coordinate / center, signed
  localparam int RootW     = 28;          // radius, root, magnitudes
  localparam int SqW       = 2 * RootW;   // squared distances
  localparam int OutCW     = 24;
  localparam int OutRW     = 25;
  localparam int DivCntW   = $clog2(SqW);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [2:0]             point_t;
  typedef logic signed [ScW-1:0]    sc_t;

  localparam sc_t CtrMax = sc_t'((64'sd1 <<< (OutCW - 1)) - 64'sd1);
  localparam sc_t CtrMin = sc_t'(-(64'sd1 <<< (OutCW - 1)));
  localparam logic [RootW-1:0] RadMax = RootW'((64'd1 << OutRW) - 64'd1);
  localparam logic [SqW-1:0]   SqrtBitInit = SqW'(1) << (SqW - 2);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DIFF,
    ST_SQ,
    ST_SEED,
    ST_SQRT,
    ST_R2,
    ST_CHECK,
    ST_GDIFF,
    ST_GMUL,
    ST_DIV,
    ST_GUPD,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    DIST_SPAN,
    DIST_SEED,
    DIST_POINT
  } dist_e;

  function automatic sc_t scale_coord(coord_t v);
    sc_t w;
    w = sc_t'(v);
    return w <<< FracW;
  endfunction

endpackage

// File: rtl/core/bsf_intf.sv
// ----------------------------------------------------------------------------
// bsf_intf
// Point input channel and sphere result channel, valid/ready.
// ----------------------------------------------------------------------------
interface bsf_point_if;
  logic            valid;
  logic            ready;
  bsf_pkg::coord_t point_x;
  bsf_pkg::coord_t point_y;
  bsf_pkg::coord_t point_z;
  logic            last_point;

  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface bsf_sphere_if;
  logic                               valid;
  logic                               ready;
  logic signed [bsf_pkg::OutCW-1:0]   center_x;
  logic signed [bsf_pkg::OutCW-1:0]   center_y;
  logic signed [bsf_pkg::OutCW-1:0]   center_z;
  logic        [bsf_pkg::OutRW-1:0]   radius;
  logic                               overflow;

  modport source (output valid, center_x, center_y, center_z, radius, overflow,
                  input ready);
  modport sink   (input valid, center_x, center_y, center_z, radius, overflow,
                  output ready);
endinterface

// File: rtl/core/bounding_sphere_fit.sv
// ----------------------------------------------------------------------------
// bounding_sphere_fit
// Ritter bounding sphere over a set of 3-D points held in an on-chip store.
// ----------------------------------------------------------------------------
// Channel    Dir  Handshake     Payload
// point_i    in   valid/ready   point_x, point_y, point_z, last_point
// sphere_o   out  valid/ready   center_x/y/z (Q.8), radius (Q.8), overflow
//
// In ST_LOAD points enter the point memory at one per cycle; extremes update.
// After the last point the sequencer owns the block: 9 squaring steps pick the
// seed axis, then each stored point costs one memory read and a distance
// check, and a point outside the sphere adds a square root and three divides.
// point_i.ready is low for the whole fit; the result sits in an output
// register, so the next set loads while it waits. Reset leaves the block
// empty and loading.
// ----------------------------------------------------------------------------
module bounding_sphere_fit (
  input  logic               clk_i,
  input  logic               rst_ni,
  bsf_point_if.sink          point_i,
  bsf_sphere_if.source       sphere_o
);

  bsf_pkg::state_e                 state_q, state_d;
  bsf_pkg::dist_e                  mode_q, mode_d, sret_q, sret_d;
  logic [1:0]                      j_q, j_d, ax_q, ax_d, k_q, k_d;
  logic [bsf_pkg::CntW-1:0]        cnt_q, cnt_d, idx_q, idx_d;
  logic                            drop_q, drop_d;
  logic                            out_v_q, out_v_d;

  bsf_pkg::point_t                 ext_q [6];
  bsf_pkg::point_t                 ext_d [6];
  bsf_pkg::sc_t                    c_q [3];
  bsf_pkg::sc_t                    c_d [3];
  bsf_pkg::sc_t                    diff_q, diff_d;
  logic [bsf_pkg::RootW-1:0]       r_q, r_d, d_q, d_d, rem_q, rem_d;
  logic [bsf_pkg::SqW-1:0]         r2_q, r2_d, best_q, best_d, acc_q, acc_d;
  logic [bsf_pkg::SqW-1:0]         sx_q, sx_d, sres_q, sres_d, sbit_q, sbit_d;
  logic [bsf_pkg::SqW-1:0]         dvd_q, dvd_d;
  logic [bsf_pkg::DivCntW-1:0]     dcnt_q, dcnt_d;
  logic signed [bsf_pkg::OutCW-1:0] ocx_q, ocy_q, ocz_q;
  logic [bsf_pkg::OutRW-1:0]       orad_q;
  logic                            oovf_q;
  logic                            out_load;

  // point memory
  bsf_pkg::point_t                 mem [bsf_pkg::MaxPoints];
  bsf_pkg::point_t                 rdata_q;
  bsf_pkg::point_t                 in_pt;
  logic                            wr_en, rd_en;
  logic [bsf_pkg::AddrW-1:0]       wr_addr, rd_addr;

  // shared datapath
  logic                            accept;
  bsf_pkg::sc_t                    opa, opb;
  logic [bsf_pkg::RootW-1:0]       mag_diff, mul_a, mul_b, root;
  logic [bsf_pkg::SqW-1:0]         prod, acc_new, trial;
  logic [bsf_pkg::RootW:0]         rem_sh, r_sum;
  logic                            div_ge;
  logic [2:0]                      lo_i, hi_i;
  bsf_pkg::sc_t                    q_s, p_s;

  assign in_pt   = '{point_i.point_z, point_i.point_y, point_i.point_x};
  assign point_i.ready = (state_q == bsf_pkg::ST_LOAD);
  assign accept  = point_i.valid && point_i.ready;

  assign sphere_o.valid    = out_v_q;
  assign sphere_o.center_x = ocx_q;
  assign sphere_o.center_y = ocy_q;
  assign sphere_o.center_z = ocz_q;
  assign sphere_o.radius   = orad_q;
  assign sphere_o.overflow = oovf_q;

  assign mag_diff = diff_q[bsf_pkg::ScW-1] ? bsf_pkg::RootW'(-diff_q)
                                           : bsf_pkg::RootW'(diff_q);
  assign prod     = bsf_pkg::SqW'(mul_a) * bsf_pkg::SqW'(mul_b);
  assign acc_new  = acc_q + prod;
  assign trial    = sres_q + sbit_q;
  assign root     = sres_q[bsf_pkg::RootW-1:0] + bsf_pkg::RootW'(sx_q != '0);
  assign r_sum    = {1'b0, r_q} + {1'b0, root} + (bsf_pkg::RootW+1)'(1);
  assign rem_sh   = {rem_q, dvd_q[bsf_pkg::SqW-1]};
  assign div_ge   = rem_sh >= {1'b0, d_q};
  assign q_s      = bsf_pkg::sc_t'(dvd_q[bsf_pkg::ScW-1:0]);
  assign p_s      = bsf_pkg::scale_coord(rdata_q[k_q]);

  // distance operands by purpose
  always_comb begin
    lo_i = {1'b0, j_q};
    hi_i = 3'd3 + {1'b0, j_q};
    opa  = '0;
    opb  = '0;
    unique case (mode_q)
      bsf_pkg::DIST_SPAN: begin
        opa = bsf_pkg::scale_coord(ext_q[lo_i][k_q]);
        opb = bsf_pkg::scale_coord(ext_q[hi_i][k_q]);
      end
      bsf_pkg::DIST_SEED: begin
        opa = bsf_pkg::scale_coord(ext_q[3'd3 + {1'b0, ax_q}][k_q]);
        opb = c_q[k_q];
      end
      bsf_pkg::DIST_POINT: begin
        opa = bsf_pkg::scale_coord(rdata_q[k_q]);
        opb = c_q[k_q];
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      bsf_pkg::ST_SQ: begin
        mul_a = mag_diff;
        mul_b = mag_diff;
      end
      bsf_pkg::ST_R2: begin
        mul_a = r_q;
        mul_b = r_q;
      end
      bsf_pkg::ST_GMUL: begin
        mul_a = mag_diff;
        mul_b = r_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    sret_d  = sret_q;
    j_d     = j_q;
    ax_d    = ax_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    drop_d  = drop_q;
    ext_d   = ext_q;
    c_d     = c_q;
    diff_d  = diff_q;
    r_d     = r_q;
    d_d     = d_q;
    r2_d    = r2_q;
    best_d  = best_q;
    acc_d   = acc_q;
    sx_d    = sx_q;
    sres_d  = sres_q;
    sbit_d  = sbit_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dcnt_d  = dcnt_q;
    out_load = 1'b0;
    out_v_d = out_v_q && !sphere_o.ready;
    wr_en   = 1'b0;
    wr_addr = cnt_q[bsf_pkg::AddrW-1:0];
    rd_en   = 1'b0;
    rd_addr = idx_q[bsf_pkg::AddrW-1:0];

    unique case (state_q)
      bsf_pkg::ST_LOAD: begin
        if (accept) begin
          if (cnt_q < bsf_pkg::CntW'(bsf_pkg::MaxPoints)) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + bsf_pkg::CntW'(1);
            for (int a = 0; a < 3; a++) begin
              if (cnt_q == '0 || in_pt[a] < ext_q[a][a]) ext_d[a] = in_pt;
              if (cnt_q == '0 || in_pt[a] > ext_q[3 + a][a]) ext_d[3 + a] = in_pt;
            end
          end else begin
            drop_d = 1'b1;
          end
          if (point_i.last_point) begin
            mode_d  = bsf_pkg::DIST_SPAN;
            j_d     = '0;
            k_d     = '0;
            acc_d   = '0;
            idx_d   = '0;
            state_d = bsf_pkg::ST_DIFF;
          end
        end
      end

      bsf_pkg::ST_DIFF: begin
        diff_d  = opa - opb;
        state_d = bsf_pkg::ST_SQ;
      end

      bsf_pkg::ST_SQ: begin
        if (k_q != 2'd2) begin
          acc_d   = acc_new;
          k_d     = k_q + 2'd1;
          state_d = bsf_pkg::ST_DIFF;
        end else begin
          unique case (mode_q)
            bsf_pkg::DIST_SPAN: begin
              // strict compare keeps the earlier axis on ties
              if (j_q == 2'd0 || acc_new > best_q) begin
                best_d = acc_new;
                ax_d   = j_q;
              end
              k_d   = '0;
              acc_d = '0;
              if (j_q == 2'd2) begin
                state_d = bsf_pkg::ST_SEED;
              end else begin
                j_d     = j_q + 2'd1;
                state_d = bsf_pkg::ST_DIFF;
              end
            end
            bsf_pkg::DIST_SEED: begin
              sx_d    = acc_new;
              sres_d  = '0;
              sbit_d  = bsf_pkg::SqrtBitInit;
              sret_d  = bsf_pkg::DIST_SEED;
              state_d = bsf_pkg::ST_SQRT;
            end
            default: begin
              if (acc_new > r2_q) begin
                sx_d    = acc_new;
                sres_d  = '0;
                sbit_d  = bsf_pkg::SqrtBitInit;
                sret_d  = bsf_pkg::DIST_POINT;
                state_d = bsf_pkg::ST_SQRT;
              end else begin
                idx_d   = idx_q + bsf_pkg::CntW'(1);
                state_d = bsf_pkg::ST_CHECK;
              end
            end
          endcase
        end
      end

      bsf_pkg::ST_SEED: begin
        for (int a = 0; a < 3; a++) begin
          c_d[a] = (bsf_pkg::scale_coord(ext_q[{1'b0, ax_q}][a]) +
                    bsf_pkg::scale_coord(ext_q[3'd3 + {1'b0, ax_q}][a])) >>> 1;
        end
        mode_d  = bsf_pkg::DIST_SEED;
        k_d     = '0;
        acc_d   = '0;
        state_d = bsf_pkg::ST_DIFF;
      end

      bsf_pkg::ST_SQRT: begin
        if (sbit_q != '0) begin
          if (sx_q >= trial) begin
            sx_d   = sx_q - trial;
            sres_d = (sres_q >> 1) + sbit_q;
          end else begin
            sres_d = sres_q >> 1;
          end
          sbit_d = sbit_q >> 2;
        end else if (sret_q == bsf_pkg::DIST_SEED) begin
          r_d     = root;
          state_d = bsf_pkg::ST_R2;
        end else begin
          d_d     = root;
          r_d     = r_sum[bsf_pkg::RootW:1];
          k_d     = '0;
          state_d = bsf_pkg::ST_GDIFF;
        end
      end

      bsf_pkg::ST_R2: begin
        r2_d    = prod;
        state_d = bsf_pkg::ST_CHECK;
      end

      bsf_pkg::ST_CHECK: begin
        if (idx_q < cnt_q) begin
          rd_en   = 1'b1;
          mode_d  = bsf_pkg::DIST_POINT;
          k_d     = '0;
          acc_d   = '0;
          state_d = bsf_pkg::ST_DIFF;
        end else begin
          state_d = bsf_pkg::ST_EMIT;
        end
      end

      bsf_pkg::ST_GDIFF: begin
        diff_d  = c_q[k_q] - p_s;
        state_d = bsf_pkg::ST_GMUL;
      end

      bsf_pkg::ST_GMUL: begin
        // rounded quotient: (|diff| * r + d/2) / d
        dvd_d   = prod + bsf_pkg::SqW'(d_q >> 1);
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = bsf_pkg::ST_DIV;
      end

      bsf_pkg::ST_DIV: begin
        rem_d = div_ge ? bsf_pkg::RootW'(rem_sh - {1'b0, d_q})
                       : rem_sh[bsf_pkg::RootW-1:0];
        dvd_d = {dvd_q[bsf_pkg::SqW-2:0], div_ge};
        if (dcnt_q == bsf_pkg::DivCntW'(bsf_pkg::SqW - 1)) begin
          state_d = bsf_pkg::ST_GUPD;
        end else begin
          dcnt_d = dcnt_q + bsf_pkg::DivCntW'(1);
        end
      end

      bsf_pkg::ST_GUPD: begin
        c_d[k_q] = diff_q[bsf_pkg::ScW-1] ? p_s - q_s : p_s + q_s;
        if (k_q == 2'd2) begin
          idx_d   = idx_q + bsf_pkg::CntW'(1);
          state_d = bsf_pkg::ST_R2;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = bsf_pkg::ST_GDIFF;
        end
      end

      bsf_pkg::ST_EMIT: begin
        if (!out_v_q || sphere_o.ready) begin
          out_load = 1'b1;
          out_v_d  = 1'b1;
          cnt_d    = '0;
          drop_d   = 1'b0;
          state_d  = bsf_pkg::ST_LOAD;
        end
      end

      default: state_d = bsf_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsf_pkg::ST_LOAD;
      mode_q  <= bsf_pkg::DIST_SPAN;
      sret_q  <= bsf_pkg::DIST_SEED;
      j_q     <= '0;
      ax_q    <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      drop_q  <= 1'b0;
      out_v_q <= 1'b0;
      sbit_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      sret_q  <= sret_d;
      j_q     <= j_d;
      ax_q    <= ax_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      drop_q  <= drop_d;
      out_v_q <= out_v_d;
      sbit_q  <= sbit_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ext_q  <= ext_d;
    c_q    <= c_d;
    diff_q <= diff_d;
    r_q    <= r_d;
    d_q    <= d_d;
    r2_q   <= r2_d;
    best_q <= best_d;
    acc_q  <= acc_d;
    sx_q   <= sx_d;
    sres_q <= sres_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    if (out_load) begin
      ocx_q  <= (c_q[0] > bsf_pkg::CtrMax) ? bsf_pkg::OutCW'(bsf_pkg::CtrMax) :
                (c_q[0] < bsf_pkg::CtrMin) ? bsf_pkg::OutCW'(bsf_pkg::CtrMin) :
                bsf_pkg::OutCW'(c_q[0]);
      ocy_q  <= (c_q[1] > bsf_pkg::CtrMax) ? bsf_pkg::OutCW'(bsf_pkg::CtrMax) :
                (c_q[1] < bsf_pkg::CtrMin) ? bsf_pkg::OutCW'(bsf_pkg::CtrMin) :
                bsf_pkg::OutCW'(c_q[1]);
      ocz_q  <= (c_q[2] > bsf_pkg::CtrMax) ? bsf_pkg::OutCW'(bsf_pkg::CtrMax) :
                (c_q[2] < bsf_pkg::CtrMin) ? bsf_pkg::OutCW'(bsf_pkg::CtrMin) :
                bsf_pkg::OutCW'(c_q[2]);
      orad_q <= (r_q > bsf_pkg::RadMax) ? bsf_pkg::OutRW'(bsf_pkg::RadMax)
                                        : bsf_pkg::OutRW'(r_q);
      oovf_q <= drop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= in_pt;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

endmodule

// File: verif/bounding_sphere_fit_tb.sv
// ----------------------------------------------------------------------------
// bounding_sphere_fit_tb
// Sends point sets through the point channel and checks each sphere result
// against a predictor of the Ritter fit. Idle and stall pressure is varied.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bounding_sphere_fit_tb;

  localparam int StoreDepth = bsf_pkg::MaxPoints;
  localparam int IdleLimit  = 1000000;

  typedef struct {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
    logic [24:0]        rad;
    logic               ovf;
  } sphere_t;

  typedef enum int { SET_WIDE, SET_CLUSTER, SET_FLAT } set_kind_e;

  // --------------------------------------------------------------------------
  class sphere_scoreboard;
    longint pts[StoreDepth][3];
    longint ext[6][3];
    int     count;
    bit     dropped;
    sphere_t pending[$];
    int     errors;

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint unsigned span2(longint a[3], longint b[3]);
      longint unsigned s;
      s = 0;
      for (int k = 0; k < 3; k++) s += mag(a[k] - b[k]) * mag(a[k] - b[k]);
      return s;
    endfunction

    function longint unsigned root_up(longint unsigned v);
      longint unsigned res, b, x;
      res = 0;
      b = 64'd1 << 62;
      x = v;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      if (res * res < v) res++;
      return res;
    endfunction

    function void fit(bit ovf);
      longint c[3], hq[3], pq[3], lo[3], hi[3], diff;
      longint unsigned best, s, r, r2, sqd, d, q;
      int ax;
      sphere_t res;
      ax = 0;
      best = span2(ext[0], ext[3]);
      for (int k = 1; k < 3; k++) begin
        s = span2(ext[k], ext[3 + k]);
        if (s > best) begin
          best = s;
          ax = k;
        end
      end
      for (int k = 0; k < 3; k++) begin
        // floor halving of a sum scaled by 256 is exact
        c[k]  = ((ext[ax][k] + ext[3 + ax][k]) * 256) >>> 1;
        hq[k] = ext[3 + ax][k] * 256;
      end
      r  = root_up(span2(hq, c));
      r2 = r * r;
      for (int i = 0; i < count; i++) begin
        for (int k = 0; k < 3; k++) pq[k] = pts[i][k] * 256;
        sqd = span2(pq, c);
        if (sqd > r2) begin
          d = root_up(sqd);
          r = (r + d + 1) >> 1;
          for (int k = 0; k < 3; k++) begin
            diff = c[k] - pq[k];
            q = (mag(diff) * r + d / 2) / d;
            c[k] = pq[k] + (diff < 0 ? -longint'(q) : longint'(q));
          end
          r2 = r * r;
        end
      end
      for (int k = 0; k < 3; k++)
        c[k] = c[k] > 8388607 ? 8388607 : (c[k] < -8388608 ? -8388608 : c[k]);
      res.cx  = c[0][23:0];
      res.cy  = c[1][23:0];
      res.cz  = c[2][23:0];
      res.rad = r > 33554431 ? 25'h1FFFFFF : r[24:0];
      res.ovf = ovf;
      pending = {pending, res};
    endfunction

    function void note_point(bsf_pkg::coord_t x, bsf_pkg::coord_t y, bsf_pkg::coord_t z,
                             logic last);
      longint p[3];
      p[0] = x; p[1] = y; p[2] = z;
      if (count < StoreDepth) begin
        if (count == 0) begin
          for (int k = 0; k < 6; k++) ext[k] = p;
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (p[k] < ext[k][k]) ext[k] = p;
            if (p[k] > ext[3 + k][k]) ext[3 + k] = p;
          end
        end
        pts[count] = p;
        count++;
      end else begin
        dropped = 1;
      end
      if (last) begin
        fit(dropped);
        count = 0;
        dropped = 0;
      end
    endfunction

    task check_result(sphere_t got);
      sphere_t exp_s;
      if (pending.size() == 0) begin
        report("sphere result with none expected");
        return;
      end
      exp_s = pending.pop_front();
      if (got.cx !== exp_s.cx) report($sformatf("center_x %0d exp %0d", got.cx, exp_s.cx));
      if (got.cy !== exp_s.cy) report($sformatf("center_y %0d exp %0d", got.cy, exp_s.cy));
      if (got.cz !== exp_s.cz) report($sformatf("center_z %0d exp %0d", got.cz, exp_s.cz));
      if (got.rad !== exp_s.rad) report($sformatf("radius %0d exp %0d", got.rad, exp_s.rad));
      if (got.ovf !== exp_s.ovf) report($sformatf("overflow %0b exp %0b", got.ovf, exp_s.ovf));
    endtask
  endclass

  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  bsf_point_if  pt ();
  bsf_sphere_if sp ();

  bounding_sphere_fit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (pt),
    .sphere_o (sp)
  );

  sphere_scoreboard sb;
  int  send_idle_pct;
  int  stall_pct;
  bit  hold_rx;
  int  quiet_cycles;
  int  items_sent;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // result side: random stall, long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp.ready <= 1'b0;
    end else begin
      sp.ready <= !hold_rx && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    sphere_t got;
    if (rst_ni && sp.valid && sp.ready) begin
      got.cx  = sp.center_x;
      got.cy  = sp.center_y;
      got.cz  = sp.center_z;
      got.rad = sp.radius;
      got.ovf = sp.overflow;
      sb.check_result(got);
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pt.valid && pt.ready) || (sp.valid && sp.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_point(bsf_pkg::coord_t x, bsf_pkg::coord_t y, bsf_pkg::coord_t z,
                            logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      pt.valid <= 1'b0;
      @(posedge clk_i);
    end
    pt.valid      <= 1'b1;
    pt.point_x    <= x;
    pt.point_y    <= y;
    pt.point_z    <= z;
    pt.last_point <= last;
    do @(posedge clk_i); while (!pt.ready);
    sb.note_point(x, y, z, last);
    items_sent++;
  endtask

  task automatic send_set(int n, set_kind_e kind);
    bsf_pkg::coord_t cx, cy, cz, x, y, z;
    int spread;
    cx = bsf_pkg::coord_t'($urandom);
    cy = bsf_pkg::coord_t'($urandom);
    cz = bsf_pkg::coord_t'($urandom);
    spread = 1 << $urandom_range(12);
    for (int i = 0; i < n; i++) begin
      case (kind)
        SET_WIDE: begin
          x = bsf_pkg::coord_t'($urandom);
          y = bsf_pkg::coord_t'($urandom);
          z = bsf_pkg::coord_t'($urandom);
        end
        SET_CLUSTER: begin
          x = cx + bsf_pkg::coord_t'($urandom_range(spread) - spread / 2);
          y = cy + bsf_pkg::coord_t'($urandom_range(spread) - spread / 2);
          z = cz + bsf_pkg::coord_t'($urandom_range(spread) - spread / 2);
        end
        default: begin
          // points on a line: ties on the unused axes
          x = cx + bsf_pkg::coord_t'($urandom_range(spread));
          y = cy;
          z = cz;
        end
      endcase
      send_point(x, y, z, i == n - 1);
    end
  endtask

  task automatic hold_result_side(int cycles);
    hold_rx <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct <= 0;  end
      1: begin send_idle_pct = 79; stall_pct <= 0;  end
      2: begin send_idle_pct = 0;  stall_pct <= 79; end
      default: begin send_idle_pct = 33; stall_pct <= 33; end
    endcase
  endtask

  initial begin
    int mode;
    sb = new();
    rst_ni        = 1'b0;
    hold_rx       = 1'b0;
    stall_pct     = 0;
    send_idle_pct = 0;
    quiet_cycles  = 0;
    items_sent    = 0;
    pt.valid      = 1'b0;
    pt.point_x    = '0;
    pt.point_y    = '0;
    pt.point_z    = '0;
    pt.last_point = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single point, extremes, ties, degenerate sets
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
    send_point(16'sd5, 16'sd5, 16'sd5, 1'b0);
    send_point(16'sd5, 16'sd5, 16'sd5, 1'b1);
    // equal spans on all axes: x pair must seed
    send_point(-16'sd100, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd100, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, -16'sd100, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd100, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, -16'sd100, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd100, 1'b1);
    // corner pair spans x and y alike, wider than z: x pair seeds
    send_point(16'sd0, 16'sd0, -16'sd32768, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd32767, 1'b0);
    send_point(16'sd32767, -16'sd32768, 16'sd0, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 16'sd1, 1'b1);
    send_point(16'sd7, -16'sd3, 16'sd1, 1'b0);
    send_point(16'sd7, 16'sd9, 16'sd1, 1'b0);
    send_point(-16'sd1, 16'sd9, -16'sd1, 1'b1);

    // long result-side hold while sets keep coming: output fills, input stalls
    fork hold_result_side(3000); join_none
    for (int s = 0; s < 8; s++) send_set(2, SET_CLUSTER);

    // store overflow: the set runs past capacity, the last six points are dropped
    send_set(StoreDepth + 6, SET_CLUSTER);

    mode = 0;
    while (items_sent < 1350) begin
      if ($urandom_range(5) == 0) begin
        mode = (mode + 1) % 4;
        set_idling(mode);
      end
      if (mode == 0 && !hold_rx && $urandom_range(15) == 0)
        fork hold_result_side(400 + $urandom_range(400)); join_none
      send_set($urandom_range(3) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 14),
               set_kind_e'($urandom_range(2)));
    end
    pt.valid <= 1'b0;
    set_idling(0);

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
